// ===== design/prc_pkg.sv =====
// Shared types and constants for the prescaled root counter channel.
`default_nettype none
package prc_pkg;

    // Item action codes.
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_HBLANK = 3'd1;
    localparam logic [2:0] ACT_MODE   = 3'd2;
    localparam logic [2:0] ACT_COUNT  = 3'd3;
    localparam logic [2:0] ACT_TARGET = 3'd4;
    localparam logic [2:0] ACT_READ   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDE_COUNTER  = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_KIND  = 2'd1;
    localparam logic [1:0] CFG_PIXEL_DIVIDER = 2'd2;

    // Channel kinds.
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HBLANK = 2'd1;
    localparam logic [1:0] KIND_DIV8   = 2'd2;
    localparam logic [1:0] KIND_MULTI  = 2'd3;

    // Bit positions in the mode register.
    localparam int MB_GATE       = 0;
    localparam int MB_TGT_RESET  = 3;
    localparam int MB_TGT_IRQ    = 4;
    localparam int MB_OVF_IRQ    = 5;
    localparam int MB_REPEAT     = 6;
    localparam int MB_TOGGLE     = 7;
    localparam int MB_ALT_SOURCE = 8;
    localparam int MB_DIV8       = 9;
    localparam int MB_IRQ_N      = 10;
    localparam int MB_TGT_FLAG   = 11;
    localparam int MB_OVF_FLAG   = 12;
    localparam int MB_PRE_LO     = 13;
    localparam int MB_PRE_HI     = 14;
    localparam int MB_GATED      = 24;

    // Reset values.
    localparam logic [31:0] MODE_RESET    = 32'h0000_0400;
    localparam logic [1:0]  KIND_RESET    = KIND_DIV8;
    localparam logic [7:0]  PIXDIV_RESET  = 8'd1;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        interrupt;
        logic        target_reached;
        logic        overflowed;
    } result_t;

    typedef struct packed {
        logic       wide_counter;
        logic [1:0] channel_kind;
        logic [7:0] pixel_divider;
    } cfg_t;

endpackage
`default_nettype wire

// ===== design/prc_cfg_regs.sv =====
// Configuration registers of the counter channel.
`default_nettype none
module prc_cfg_regs
    import prc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_WIDE_COUNTER:  cfg_next.wide_counter  = cfg_data[0];
                CFG_CHANNEL_KIND:  cfg_next.channel_kind  = cfg_data[1:0];
                CFG_PIXEL_DIVIDER: cfg_next.pixel_divider = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wide_counter  <= 1'b0;
            cfg_reg.channel_kind  <= KIND_RESET;
            cfg_reg.pixel_divider <= PIXDIV_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== design/prc_timer_core.sv =====
// Counter state and the single-pass update that one item applies to it.
`default_nettype none
module prc_timer_core
    import prc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  item_fire,
    input  wire item_t item,
    output result_t    result
);

    logic [32:0] count_reg,  count_next;
    logic [31:0] target_reg, target_next;
    logic        armed_reg,  armed_next;
    logic [31:0] mode_reg,   mode_next;
    logic [8:0]  pscnt_reg,  pscnt_next;
    logic [8:0]  limit_reg,  limit_next;
    logic        stopped_reg, stopped_next;

    logic [32:0] mask;
    logic [32:0] tgt;
    logic [32:0] masked_data;
    logic [8:0]  pscnt_inc;
    logic        hblank_src;
    logic        run_tests;

    // Prescale limit implied by the channel kind and a newly written mode.
    function automatic logic [8:0] limit_for(input logic [1:0] kind,
                                             input logic [7:0] pixdiv,
                                             input logic [31:0] m);
        logic [8:0] lim;
        lim = 9'd1;
        unique case (kind)
            KIND_PIXEL: begin
                if (m[MB_ALT_SOURCE] && pixdiv != 8'd0) begin
                    lim = {1'b0, pixdiv};
                end
            end
            KIND_HBLANK: lim = 9'd1;
            KIND_DIV8:   lim = m[MB_DIV8] ? 9'd8 : 9'd1;
            default: begin
                case (m[MB_PRE_HI:MB_PRE_LO])
                    2'd0:    lim = 9'd1;
                    2'd1:    lim = 9'd8;
                    2'd2:    lim = 9'd16;
                    default: lim = 9'd256;
                endcase
            end
        endcase
        return lim;
    endfunction

    always_comb begin
        count_next   = count_reg;
        target_next  = target_reg;
        armed_next   = armed_reg;
        mode_next    = mode_reg;
        pscnt_next   = pscnt_reg;
        limit_next   = limit_reg;
        stopped_next = stopped_reg;
        result       = '0;
        run_tests    = 1'b0;

        mask        = cfg.wide_counter ? 33'h0_FFFF_FFFF : 33'h0_0000_FFFF;
        masked_data = {1'b0, item.write_data} & mask;
        hblank_src  = (cfg.channel_kind == KIND_HBLANK) && mode_reg[MB_ALT_SOURCE];
        pscnt_inc   = pscnt_reg + 9'd1;
        tgt         = {1'b0, target_reg} & mask;

        unique case (item.action)
            ACT_TICK: begin
                if (!stopped_reg && !hblank_src) begin
                    pscnt_next = pscnt_inc;
                    if (pscnt_inc >= limit_reg) begin
                        pscnt_next = '0;
                        count_next = count_reg + 33'd1;
                    end
                end
                run_tests = 1'b1;
            end
            ACT_HBLANK: begin
                if (hblank_src) begin
                    if (!stopped_reg) begin
                        count_next = count_reg + 33'd1;
                    end
                    run_tests = 1'b1;
                end
            end
            ACT_MODE: begin
                mode_next = item.write_data;
                mode_next[MB_IRQ_N] = 1'b1;
                limit_next = limit_for(cfg.channel_kind, cfg.pixel_divider,
                                       item.write_data);
                if (cfg.channel_kind == KIND_PIXEL || cfg.channel_kind == KIND_HBLANK) begin
                    if (item.write_data[MB_GATE]) begin
                        mode_next[MB_GATED] = 1'b1;
                    end
                end else if (item.write_data[2:0] == 3'd7 || item.write_data[2:0] == 3'd1) begin
                    mode_next[MB_GATED] = 1'b1;
                end
                stopped_next = item.write_data[MB_GATE];
                count_next   = '0;
                pscnt_next   = '0;
                armed_next   = 1'b1;
            end
            ACT_COUNT: begin
                count_next = masked_data;
                armed_next = 1'b1;
            end
            ACT_TARGET: begin
                target_next = masked_data[31:0];
                armed_next  = masked_data > count_reg;
            end
            ACT_READ: begin
                if (item.write_data[0]) begin
                    result.read_data = mode_reg;
                end else begin
                    result.read_data = count_reg[31:0] & mask[31:0];
                end
            end
            default: ;
        endcase

        if (run_tests) begin
            // Target test, then overflow test on what it leaves.
            if (armed_reg && count_next >= tgt) begin
                result.target_reached = 1'b1;
                if (mode_next[MB_TGT_IRQ]) begin
                    if (mode_next[MB_TOGGLE]) begin
                        mode_next[MB_IRQ_N] = 1'b0;
                    end
                    mode_next[MB_TGT_FLAG] = 1'b1;
                    result.interrupt = 1'b1;
                end
                if (mode_next[MB_TGT_RESET]) begin
                    count_next = count_next - tgt;
                    if (!mode_next[MB_REPEAT]) begin
                        armed_next = 1'b0;
                    end
                end else begin
                    armed_next = 1'b0;
                end
            end
            if (count_next > mask) begin
                result.overflowed = 1'b1;
                if (mode_next[MB_OVF_IRQ]) begin
                    result.interrupt = 1'b1;
                    mode_next[MB_OVF_FLAG] = 1'b1;
                    if (mode_next[MB_TOGGLE]) begin
                        mode_next[MB_IRQ_N] = 1'b0;
                    end
                end
                count_next = count_next & mask;
                armed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            target_reg  <= '0;
            armed_reg   <= 1'b1;
            mode_reg    <= MODE_RESET;
            pscnt_reg   <= '0;
            limit_reg   <= 9'd1;
            stopped_reg <= 1'b0;
        end else if (item_fire) begin
            count_reg   <= count_next;
            target_reg  <= target_next;
            armed_reg   <= armed_next;
            mode_reg    <= mode_next;
            pscnt_reg   <= pscnt_next;
            limit_reg   <= limit_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/prescaled_root_counter_channel_core.sv =====
// Top level of the prescaled root counter channel: handshakes and pipeline registers.
//
// The s_ channel carries one item per handshake: a system tick, an hblank
// pulse, a write of the mode, count or target register, or a read. Every
// item produces exactly one result item on the m_ channel, carrying the read
// data (zero except for reads) and the interrupt, target and overflow pulses.
// The cfg_ channel writes wide_counter, channel_kind and pixel_divider; it is
// always ready and should only be used while no item is in flight.
// An accepted item sits in the input register until the result register is
// empty or is being emptied; it is then applied to the counter state, and
// its result lands in the result register at the edge that updates the state.
// One item is taken per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more; once both are full, s_ready drops until the
// receiver takes the result. Reset clears both stages and returns the counter
// state and configuration to their reset values.
`default_nettype none
module prescaled_root_counter_channel_core
    import prc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output wire logic        s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [31:0] s_write_data,
    output wire logic        m_valid,
    input  wire logic        m_ready,
    output wire logic [31:0] m_read_data,
    output wire logic        m_interrupt,
    output wire logic        m_target_reached,
    output wire logic        m_overflowed,
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_result_reg;
    logic    out_valid_reg;
    logic    advance;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    prc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prc_timer_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item_fire (advance),
        .item      (in_item_reg),
        .result    (core_result)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.action     <= s_action;
            in_item_reg.write_data <= s_write_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_read_data      = out_result_reg.read_data;
    assign m_interrupt      = out_result_reg.interrupt;
    assign m_target_reached = out_result_reg.target_reached;
    assign m_overflowed     = out_result_reg.overflowed;

endmodule
`default_nettype wire

// ===== dv/prescaled_root_counter_channel_core_tb.sv =====
// Self-checking testbench for the prescaled root counter channel core.
`default_nettype none
module prescaled_root_counter_channel_core_tb;
    import prc_pkg::*;

    // Action codes that the block does not use; they must leave the state alone.
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    // Low mode bit patterns that mark a gated count on the divided channel kinds.
    localparam logic [2:0] GATE_PAT_ONCE = 3'd1;
    localparam logic [2:0] GATE_PAT_HOLD = 3'd7;

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 4000;

    // Settling time for the pipeline once the last owed result has been taken.
    localparam int PIPE_CYCLES = 3;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = ACT_TICK;
    logic [31:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic        m_interrupt;
    logic        m_target_reached;
    logic        m_overflowed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_WIDE_COUNTER;
    logic [7:0]  cfg_data = '0;

    prescaled_root_counter_channel_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_write_data     (s_write_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_data      (m_read_data),
        .m_interrupt      (m_interrupt),
        .m_target_reached (m_target_reached),
        .m_overflowed     (m_overflowed),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Timer channel predictor. It mirrors the configuration registers and
    // the counter state, and is advanced once for every accepted item.
    // ------------------------------------------------------------------
    logic        wide_q;
    logic [1:0]  kind_q;
    logic [7:0]  pixdiv_q;

    logic [32:0] cnt;
    logic [31:0] tgt;
    logic        armed;
    logic [31:0] mode;
    logic [8:0]  pre_cnt;
    logic [8:0]  pre_lim;
    logic        stopped;

    // Results still owed by the block, oldest first.
    result_t     owed_results[$];

    int          errors = 0;
    int          results_checked = 0;
    int          stim_items = 0;
    int          phases = 0;
    int          burst_left = 0;

    function automatic void timer_reset();
        wide_q   = 1'b0;
        kind_q   = KIND_RESET;
        pixdiv_q = PIXDIV_RESET;
        cnt      = '0;
        tgt      = '0;
        armed    = 1'b1;
        mode     = MODE_RESET;
        pre_cnt  = '0;
        pre_lim  = 9'd1;
        stopped  = 1'b0;
    endfunction

    function automatic logic [31:0] bit_of(int pos);
        return 32'd1 << pos;
    endfunction

    function automatic logic [32:0] span_mask();
        return wide_q ? 33'h0_FFFF_FFFF : 33'h0_0000_FFFF;
    endfunction

    function automatic logic counts_hblank();
        return kind_q == KIND_HBLANK && mode[MB_ALT_SOURCE];
    endfunction

    // With the toggle bit set, every interrupt drops the interrupt bit.
    function automatic void irq_fired();
        if (mode[MB_TOGGLE])
            mode[MB_IRQ_N] = 1'b0;
    endfunction

    // Ticks per count step for a newly written mode word.
    function automatic logic [8:0] divide_for(logic [31:0] v);
        case (kind_q)
            KIND_PIXEL: begin
                if (!v[MB_ALT_SOURCE])
                    return 9'd1;
                return (pixdiv_q == 8'd0) ? 9'd1 : {1'b0, pixdiv_q};
            end
            KIND_HBLANK: return 9'd1;
            KIND_DIV8:   return v[MB_DIV8] ? 9'd8 : 9'd1;
            default: begin
                case (v[MB_PRE_HI:MB_PRE_LO])
                    2'd0:    return 9'd1;
                    2'd1:    return 9'd8;
                    2'd2:    return 9'd16;
                    default: return 9'd256;
                endcase
            end
        endcase
    endfunction

    // Target and overflow tests; returns {interrupt, target, overflow}.
    function automatic logic [2:0] run_limits();
        logic [32:0] m;
        logic [32:0] t;
        logic [2:0]  f;
        m = span_mask();
        t = {1'b0, tgt} & m;
        f = '0;
        if (armed && cnt >= t) begin
            f[1] = 1'b1;
            if (mode[MB_TGT_IRQ]) begin
                irq_fired();
                mode[MB_TGT_FLAG] = 1'b1;
                f[2] = 1'b1;
            end
            if (mode[MB_TGT_RESET]) begin
                cnt = cnt - t;
                if (!mode[MB_REPEAT])
                    armed = 1'b0;
            end else begin
                armed = 1'b0;
            end
        end
        if (cnt > m) begin
            f[0] = 1'b1;
            if (mode[MB_OVF_IRQ]) begin
                f[2] = 1'b1;
                mode[MB_OVF_FLAG] = 1'b1;
                irq_fired();
            end
            cnt   = cnt & m;
            armed = 1'b1;
        end
        return f;
    endfunction

    function automatic result_t timer_step(logic [2:0] act, logic [31:0] data);
        result_t     r;
        logic [2:0]  f;
        logic [32:0] m;
        r = '0;
        f = '0;
        m = span_mask();
        case (act)
            ACT_TICK: begin
                if (!stopped && !counts_hblank()) begin
                    pre_cnt = pre_cnt + 9'd1;
                    if (pre_cnt >= pre_lim) begin
                        pre_cnt = '0;
                        cnt = cnt + 33'd1;
                    end
                end
                f = run_limits();
            end
            ACT_HBLANK: begin
                if (counts_hblank()) begin
                    if (!stopped)
                        cnt = cnt + 33'd1;
                    f = run_limits();
                end
            end
            ACT_MODE: begin
                mode = data;
                mode[MB_IRQ_N] = 1'b1;
                pre_lim = divide_for(data);
                if (kind_q == KIND_PIXEL || kind_q == KIND_HBLANK) begin
                    if (mode[MB_GATE])
                        mode[MB_GATED] = 1'b1;
                end else if (mode[2:0] == GATE_PAT_HOLD || mode[2:0] == GATE_PAT_ONCE) begin
                    mode[MB_GATED] = 1'b1;
                end
                stopped = mode[MB_GATE];
                cnt     = '0;
                pre_cnt = '0;
                armed   = 1'b1;
            end
            ACT_COUNT: begin
                cnt   = {1'b0, data} & m;
                armed = 1'b1;
            end
            ACT_TARGET: begin
                tgt   = data & m[31:0];
                armed = {1'b0, tgt} > cnt;
            end
            ACT_READ: begin
                r.read_data = data[0] ? mode : (cnt[31:0] & m[31:0]);
            end
            default: begin
            end
        endcase
        {r.interrupt, r.target_reached, r.overflowed} = f;
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: all three channels are sampled at the rising edge, while the
    // inputs only ever move on the falling edge. A result is compared before
    // the item taken at the same edge is predicted, since that item's own
    // result is not offered before the next edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            timer_reset();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WIDE_COUNTER:  wide_q   = cfg_data[0];
                    CFG_CHANNEL_KIND:  kind_q   = cfg_data[1:0];
                    CFG_PIXEL_DIVIDER: pixdiv_q = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_read_data, m_interrupt, m_target_reached, m_overflowed};
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result item, expected none, got read_data 0x%08h",
                             $time, m_read_data);
                end else begin
                    want = owed_results.pop_front();
                    results_checked++;
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("interrupt", 32'(want.interrupt), 32'(got.interrupt));
                    check_field("target_reached", 32'(want.target_reached),
                                32'(got.target_reached));
                    check_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
                end
            end
            if (s_valid && s_ready)
                owed_results.push_back(timer_step(s_action, s_write_data));
        end
    end

    // Watchdog: a correct block always moves something well within the limit.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results still owed",
                     $time, STALL_LIMIT, owed_results.size());
            $display("prescaled_root_counter_channel_core regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure. The style changes every so often so that stalls
    // land on every phase of the pipeline, with some stretches fully open.
    int rx_cycle = 0;
    int rx_style = 0;
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0)
            rx_style <= $urandom_range(0, 3);
        case (rx_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_cycle % 4 != 3);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge and returns at a falling edge with
    // valid still high, so back-to-back items keep valid asserted. Items go
    // out in bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] act, input logic [31:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_action     <= act;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every owed result has been taken, then let
    // the pipeline settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (owed_results.size() != 0) @(negedge aclk);
        repeat (PIPE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Configuration only changes with the channel idle.
    task automatic set_config(input logic wide, input logic [1:0] kind, input logic [7:0] div);
        drain_results();
        cfg_write(CFG_WIDE_COUNTER, {7'd0, wide});
        cfg_write(CFG_CHANNEL_KIND, {6'd0, kind});
        cfg_write(CFG_PIXEL_DIVIDER, div);
        cfg_valid <= 1'b0;
        phases++;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Reads after reset, the read selector, unused actions and masked writes.
    task automatic test_register_access();
        send_item(ACT_READ, 32'h0000_0000);
        send_item(ACT_READ, 32'hFFFF_FFFF);
        send_item(ACT_READ, 32'hFFFF_FFFE);
        send_item(ACT_SPARE_A, 32'hFFFF_FFFF);
        send_item(ACT_SPARE_B, 32'h0000_0000);
        send_item(ACT_HBLANK, 32'hFFFF_FFFF);
        send_item(ACT_COUNT, 32'hFFFF_FFF0);
        // A target at or below the count must not arm.
        send_item(ACT_TARGET, 32'h0001_0005);
        send_item(ACT_TICK, 32'hFFFF_FFFF);
        send_item(ACT_READ, 32'h0000_0000);
        stim_items += 10;
    endtask

    // Target hit with reset and repeat, overflow with interrupt, the toggle
    // bit clearing the interrupt bit, a gated count and the divide by eight.
    task automatic test_target_and_overflow();
        send_item(ACT_MODE, bit_of(MB_TGT_RESET) | bit_of(MB_TGT_IRQ) |
                            bit_of(MB_OVF_IRQ) | bit_of(MB_REPEAT));
        send_item(ACT_TARGET, 32'd2);
        repeat (3) send_item(ACT_TICK, 32'd0);
        send_item(ACT_COUNT, 32'h0000_FFFF);
        send_item(ACT_TICK, 32'd0);
        send_item(ACT_MODE, bit_of(MB_TOGGLE) | bit_of(MB_TGT_IRQ));
        send_item(ACT_TARGET, 32'd1);
        repeat (2) send_item(ACT_TICK, 32'd0);
        send_item(ACT_READ, 32'd1);
        // Gated: the count holds, yet the tests still run on every tick.
        send_item(ACT_MODE, bit_of(MB_GATE));
        send_item(ACT_COUNT, 32'd5);
        send_item(ACT_TICK, 32'd0);
        send_item(ACT_MODE, bit_of(MB_DIV8));
        repeat (9) send_item(ACT_TICK, 32'd0);
        send_item(ACT_READ, 32'd0);
        stim_items += 26;
    endtask

    // Hblank counting, a zero pixel divider and a width narrowed under a
    // count that no longer fits.
    task automatic test_config_corners();
        set_config(1'b1, KIND_HBLANK, 8'd0);
        send_item(ACT_MODE, bit_of(MB_ALT_SOURCE) | bit_of(MB_TGT_IRQ));
        send_item(ACT_TARGET, 32'd2);
        repeat (2) send_item(ACT_HBLANK, 32'd0);
        send_item(ACT_TICK, 32'd0);
        send_item(ACT_COUNT, 32'h0001_2345);
        set_config(1'b0, KIND_PIXEL, 8'd0);
        send_item(ACT_TICK, 32'd0);
        send_item(ACT_MODE, bit_of(MB_ALT_SOURCE));
        repeat (2) send_item(ACT_TICK, 32'd0);
        send_item(ACT_READ, 32'd0);
        stim_items += 11;
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------

    // One well-formed sequence: a mode word, a count near an edge of the
    // range or anywhere in it, a target usually a little ahead, then mostly
    // ticks with reads, hblank pulses, stray writes and unused actions mixed in.
    task automatic run_sequence();
        logic [31:0] top;
        logic [31:0] start;
        logic [31:0] word;
        int          len;
        int          pick;
        top  = wide_q ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        word = $urandom;
        if ($urandom_range(0, 3) != 0)
            word[MB_GATE] = 1'b0;
        if ($urandom_range(0, 2) != 0)
            word[MB_PRE_HI:MB_PRE_LO] = 2'd0;
        send_item(ACT_MODE, word);
        stim_items++;
        case ($urandom_range(0, 3))
            0:       start = top - $urandom_range(0, 40);
            1:       start = $urandom_range(0, 20);
            2:       start = $urandom;
            default: start = '0;
        endcase
        send_item(ACT_COUNT, start);
        send_item(ACT_TARGET, ($urandom_range(0, 5) == 0) ? $urandom
                                                          : start + $urandom_range(1, 30));
        stim_items += 2;
        len = $urandom_range(8, 40);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                send_item(ACT_TICK, $urandom);
            end else if (pick < 78) begin
                send_item(ACT_HBLANK, $urandom);
            end else if (pick < 86) begin
                send_item(ACT_READ, $urandom);
            end else if (pick < 90) begin
                send_item(ACT_COUNT, ($urandom_range(0, 1) == 1) ? $urandom
                                                                  : top - $urandom_range(0, 8));
            end else if (pick < 94) begin
                send_item(ACT_TARGET, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64));
            end else if (pick < 96) begin
                send_item(ACT_MODE, $urandom);
            end else begin
                // Unused actions change nothing and are not counted.
                send_item($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B, $urandom);
                stim_items--;
            end
            stim_items++;
        end
    endtask

    // Phases over the configuration space, extremes first, then random ones.
    task automatic test_random_traffic();
        logic       wide;
        logic [1:0] kind;
        logic [7:0] div;
        int         goal;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       {wide, kind, div} = {1'b0, KIND_DIV8,   8'd1};
                1:       {wide, kind, div} = {1'b1, KIND_MULTI,  8'd255};
                2:       {wide, kind, div} = {1'b0, KIND_PIXEL,  8'd0};
                3:       {wide, kind, div} = {1'b1, KIND_HBLANK, 8'd255};
                4:       {wide, kind, div} = {1'b0, KIND_MULTI,  8'd1};
                5:       {wide, kind, div} = {1'b1, KIND_PIXEL,  8'd2};
                6:       {wide, kind, div} = {1'b0, KIND_HBLANK, 8'd0};
                default: {wide, kind, div} = {1'($urandom_range(0, 1)),
                                              2'($urandom_range(0, 3)),
                                              8'($urandom_range(0, 255))};
            endcase
            set_config(wide, kind, div);
            goal = stim_items + 72;
            while (stim_items < goal) begin
                run_sequence();
                // Now and then hold off until the channel has fully caught up.
                if ($urandom_range(0, 9) == 0)
                    drain_results();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_register_access();
        test_target_and_overflow();
        test_config_corners();
        test_random_traffic();

        drain_results();
        repeat (2 * PIPE_CYCLES) @(posedge aclk);

        $display("Covered %0d items over %0d configuration settings, directed corners first.",
                 stim_items, phases);
        $display("Checked %0d result items; %0d mismatches.", results_checked, errors);
        if (errors == 0 && owed_results.size() == 0) begin
            $display("prescaled_root_counter_channel_core regression: pass");
        end else begin
            $display("prescaled_root_counter_channel_core regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
